@@ rtl/core/urmd_pkg.sv @@
// ----------------------------------------------------------------------------
// urmd_pkg
// Shared types and constants of the ultrasonic range and motion detector:
// phase encoding, register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package urmd_pkg;

  localparam int TICK_W   = 20;  // tick counter width
  localparam int DIST_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TRIG = 3'd1,
    PH_RISE = 3'd2,
    PH_HIGH = 3'd3,
    PH_GAP  = 3'd4
  } phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_CM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_CM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS = 3'd5;

  localparam logic [7:0]        RST_TRIG_TICKS   = 8'd10;
  localparam logic [15:0]       RST_ECHO_TIMEOUT = 16'd25000;
  localparam logic [7:0]        RST_TICKS_PER_CM = 8'd58;
  localparam logic [15:0]       RST_THRESHOLD_CM = 16'd200;
  localparam logic [19:0]       RST_PERIOD_TICKS = 20'd100000;
  localparam logic [DIST_W-1:0] DIST_MAX         = 16'hFFFF;

endpackage

@@ rtl/core/ultrasonic_range_motion_detector.sv @@
// an accepted input word is registered and shows as a result word on the next cycle
// throughput: one word per cycle while the result stream takes words; one result word for every input word
// the phase and counters step once per word through short compare/increment logic
// in_tready drops only while the output register holds a word that is not taken
// reset (rst_n low, synchronous): idle phase, counters zero, registers to defaults,
// distance 0, no_echo 1, motion 0, output register empty
// ----------------------------------------------------------------------------
// ultrasonic_range_motion_detector
// Per-tick echo ranging controller: trigger pulse, echo rise wait, echo width
// count in centimetres, timeout handling and a motion flag with change event.
// ----------------------------------------------------------------------------
module ultrasonic_range_motion_detector
  import urmd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [0] echo_level, [7:1] zero
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] trig_out, [1] measure_done, [17:2] distance_cm, [18] no_echo,
  // [19] motion, [20] motion_changed, [23:21] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // configuration write channel
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DAT_W-1:0]   cfg_data
);

  // configuration registers
  logic        enable_r;
  logic [7:0]  trig_ticks_r;
  logic [15:0] echo_timeout_r;
  logic [7:0]  ticks_per_cm_r;
  logic [15:0] threshold_cm_r;
  logic [19:0] period_ticks_r;

  // measurement state
  phase_t              phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [7:0]          sub_r, sub_nxt;
  logic [DIST_W-1:0]   cm_r, cm_nxt;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic                no_echo_r, no_echo_nxt;
  logic                motion_r, motion_nxt;

  // output register
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_fire;
  logic              echo;
  logic              trig;
  logic              done;
  logic              changed;
  logic              fin;
  logic              fin_timeout;
  logic              det;
  logic [TICK_W-1:0] tick_inc;
  logic [7:0]        sub_inc;

  assign cfg_ready = 1'b1;
  assign in_tready = out_tready | ~out_valid_r;
  assign in_fire   = in_tvalid & in_tready;
  assign echo      = in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r       <= 1'b0;
      trig_ticks_r   <= RST_TRIG_TICKS;
      echo_timeout_r <= RST_ECHO_TIMEOUT;
      ticks_per_cm_r <= RST_TICKS_PER_CM;
      threshold_cm_r <= RST_THRESHOLD_CM;
      period_ticks_r <= RST_PERIOD_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ENABLE:       enable_r       <= cfg_data[0];
        REG_TRIG_TICKS:   trig_ticks_r   <= cfg_data[7:0];
        REG_ECHO_TIMEOUT: echo_timeout_r <= cfg_data[15:0];
        REG_TICKS_PER_CM: ticks_per_cm_r <= cfg_data[7:0];
        REG_THRESHOLD_CM: threshold_cm_r <= cfg_data[15:0];
        REG_PERIOD_TICKS: period_ticks_r <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      tick_r    <= '0;
      sub_r     <= '0;
      cm_r      <= '0;
      dist_r    <= '0;
      no_echo_r <= 1'b1;
      motion_r  <= 1'b0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      tick_r    <= tick_nxt;
      sub_r     <= sub_nxt;
      cm_r      <= cm_nxt;
      dist_r    <= dist_nxt;
      no_echo_r <= no_echo_nxt;
      motion_r  <= motion_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    tick_nxt    = tick_r;
    sub_nxt     = sub_r;
    cm_nxt      = cm_r;
    dist_nxt    = dist_r;
    no_echo_nxt = no_echo_r;
    motion_nxt  = motion_r;
    trig        = 1'b0;
    done        = 1'b0;
    changed     = 1'b0;
    fin         = 1'b0;
    fin_timeout = 1'b0;
    det         = 1'b0;
    tick_inc    = '0;
    sub_inc     = '0;

    if (!enable_r) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = '0;
    end else begin
      // gap end and idle start fall through into the trigger phase this tick
      if (phase_nxt == PH_GAP) begin
        if (tick_r >= TICK_W'(period_ticks_r)) begin
          phase_nxt = PH_IDLE;
        end else begin
          tick_nxt = tick_r + TICK_W'(1);
        end
      end
      if (phase_nxt == PH_IDLE) begin
        phase_nxt = PH_TRIG;
        tick_nxt  = '0;
      end
      tick_inc = tick_nxt + TICK_W'(1);
      case (phase_nxt)
        PH_TRIG: begin
          trig = 1'b1;
          if (tick_inc >= TICK_W'(trig_ticks_r)) begin
            phase_nxt = PH_RISE;
            tick_nxt  = '0;
          end else begin
            tick_nxt = tick_inc;
          end
        end
        PH_RISE: begin
          if (echo) begin
            // rise tick counts as the first width tick
            phase_nxt = PH_HIGH;
            tick_nxt  = TICK_W'(1);
            if (ticks_per_cm_r <= 8'd1) begin
              sub_nxt = '0;
              cm_nxt  = DIST_W'(1);
            end else begin
              sub_nxt = 8'd1;
              cm_nxt  = '0;
            end
          end else begin
            tick_nxt = tick_inc;
            if (tick_inc >= TICK_W'(echo_timeout_r)) begin
              fin         = 1'b1;
              fin_timeout = 1'b1;
            end
          end
        end
        PH_HIGH: begin
          if (!echo) begin
            fin = 1'b1;
          end else if (tick_nxt >= TICK_W'(echo_timeout_r)) begin
            fin         = 1'b1;
            fin_timeout = 1'b1;
          end else begin
            tick_nxt = tick_inc;
            sub_inc  = sub_r + 8'd1;
            if (sub_inc >= ticks_per_cm_r) begin
              sub_nxt = '0;
              if (cm_r != DIST_MAX) begin
                cm_nxt = cm_r + DIST_W'(1);
              end
            end else begin
              sub_nxt = sub_inc;
            end
          end
        end
        default: ;
      endcase

      if (fin) begin
        done        = 1'b1;
        dist_nxt    = fin_timeout ? DIST_MAX : cm_r;
        no_echo_nxt = fin_timeout;
        det         = ~fin_timeout && (cm_r != '0) && (cm_r <= threshold_cm_r);
        changed     = det ^ motion_r;
        motion_nxt  = det;
        phase_nxt   = PH_GAP;
        tick_nxt    = '0;
      end
    end

    out_data_nxt = {3'b000, changed, motion_nxt, no_echo_nxt, dist_nxt, done, trig};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a disabled tick always leaves the block idle
  a_disable_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !enable_r) |=> (phase_r == PH_IDLE))
    else $error("phase not idle after disabled word");

  // the trigger is never driven on the tick a measurement completes
  a_trig_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r[0] && out_data_r[1]))
    else $error("trigger and measure_done in same word");

  // motion needs a valid echo
  a_motion_valid: assert property (@(posedge clk) disable iff (!rst_n)
    motion_r |-> (!no_echo_r && (dist_r != '0) && (dist_r != DIST_MAX || !no_echo_r)))
    else $error("motion flag set without a valid distance");

endmodule
